// ===== sv/grsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_pkg: shared types and constants for the guillotine slot packer
// Field widths, register indexes, item codes and the control/status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package grsp_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SLOTS  = 64;
  localparam int DEF_COORD_BITS = 13;

  // Fixed field widths
  localparam int BLK_W  = 13;  // block_width / block_height
  localparam int POS_W  = 12;  // pos_u / pos_v
  localparam int CFG_W  = 13;  // widest config register
  localparam int CFG_AW = 1;   // config register index

  // Config register indexes
  localparam logic [CFG_AW-1:0] CFG_PAGE_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_PAGE_HEIGHT = 1'd1;

  // Reset values of the config registers
  localparam logic [CFG_W-1:0] PAGE_SIZE_RST = 13'd512;

  // Item kind codes
  localparam logic KIND_PLACE    = 1'b0;
  localparam logic KIND_NEW_PAGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWPG,
    ST_SCAN,
    ST_SHIFT,
    ST_RSPLIT,
    ST_BSPLIT,
    ST_FIN
  } grsp_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_item;
    logic new_page;
    logic scan_step;
    logic shift_step;
    logic right_split;
    logic bottom_split;
    logic result_load;
  } grsp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_kind;
    logic in_skip;
    logic hit;
    logic miss;
    logic shift_done;
    logic out_busy;
  } grsp_sts_t;

endpackage
`default_nettype wire

// ===== sv/grsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_if: valid/ready channels of the slot packer
// grsp_in_if carries placement requests, grsp_out_if carries results.
// ----------------------------------------------------------------------------
interface grsp_in_if;
  import grsp_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [BLK_W-1:0] block_width;
  logic [BLK_W-1:0] block_height;

  modport source (output valid, kind, block_width, block_height, input ready);
  modport sink   (input valid, kind, block_width, block_height, output ready);
endinterface

interface grsp_out_if;
  import grsp_pkg::*;

  logic             valid;
  logic             ready;
  logic             placed;
  logic [POS_W-1:0] pos_u;
  logic [POS_W-1:0] pos_v;
  logic             page_full;
  logic             overflow;

  modport source (output valid, placed, pos_u, pos_v, page_full, overflow,
                  input ready);
  modport sink   (input valid, placed, pos_u, pos_v, page_full, overflow,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/guillotine_rect_slot_packer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// guillotine_rect_slot_packer_core: first-fit guillotine rectangle packer
// Keeps an ordered list of free slots of one page and places blocks at the
// origin of the first slot that holds them, splitting off right/bottom space.
//
//   channel  | dir | handshake          | beat
//   in_chan  | in  | valid/ready        | kind, block_width, block_height
//   out_chan | out | valid/ready        | placed, pos_u, pos_v, page_full,
//            |     |                    | overflow
//   cfg_*    | in  | cfg_we (no stall)  | cfg_addr, cfg_wdata
//
// One item at a time. A placement taking the slot at list position j scans
// positions 0..j, one slot per cycle from the single read port of the slot
// RAM, then moves positions 0..j-1 up one and writes the right/bottom splits.
// No fit: the whole list is scanned. New page: one slot written. Skipped: no scan.
// Reset (synchronous, rst_n low) empties the list; the RAM needs no clearing.
// A stalled out_chan holds the result; the next beat is taken and then waits
// in its last cycle until the held beat is gone.
// ----------------------------------------------------------------------------
module guillotine_rect_slot_packer_core #(
  parameter int MAX_SLOTS  = grsp_pkg::DEF_MAX_SLOTS,
  parameter int COORD_BITS = grsp_pkg::DEF_COORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [grsp_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [grsp_pkg::CFG_W-1:0]  cfg_wdata,
  grsp_in_if.sink                          in_chan,
  grsp_out_if.source                       out_chan
);
  import grsp_pkg::*;

  grsp_cmd_t cmd;
  grsp_sts_t sts;

  grsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grsp_dpath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_chan.kind),
    .in_block_width  (in_chan.block_width),
    .in_block_height (in_chan.block_height),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_placed      (out_chan.placed),
    .out_pos_u       (out_chan.pos_u),
    .out_pos_v       (out_chan.pos_v),
    .out_page_full   (out_chan.page_full),
    .out_overflow    (out_chan.overflow)
  );

endmodule
`default_nettype wire

// ===== sv/grsp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/grsp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_ctrl: sequencing FSM of the slot packer
// Steps one item through scan, list shift, splits and result hand-off.
// ----------------------------------------------------------------------------
module grsp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire grsp_pkg::grsp_sts_t sts,
  output      grsp_pkg::grsp_cmd_t cmd
);
  import grsp_pkg::*;

  grsp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.in_kind == KIND_NEW_PAGE) begin
            state_nxt = ST_NEWPG;
          end else if (sts.in_skip) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_NEWPG: begin
        cmd.new_page = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_SHIFT;
        end else if (sts.miss) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) begin
          state_nxt = ST_RSPLIT;
        end
      end
      ST_RSPLIT: begin
        cmd.right_split = 1'b1;
        state_nxt       = ST_BSPLIT;
      end
      ST_BSPLIT: begin
        cmd.bottom_split = 1'b1;
        state_nxt        = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.result_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/grsp_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_dpath: slot list storage and arithmetic of the slot packer
// Free slots live in a circular buffer (head + count) in RAM; logical list
// position k sits at physical entry (head + k) mod MAX_SLOTS.
// ----------------------------------------------------------------------------
module grsp_dpath #(
  parameter int MAX_SLOTS  = grsp_pkg::DEF_MAX_SLOTS,
  parameter int COORD_BITS = grsp_pkg::DEF_COORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire grsp_pkg::grsp_cmd_t         cmd,
  output      grsp_pkg::grsp_sts_t         sts,
  input  wire logic                        cfg_we,
  input  wire logic [grsp_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [grsp_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        in_kind,
  input  wire logic [grsp_pkg::BLK_W-1:0]  in_block_width,
  input  wire logic [grsp_pkg::BLK_W-1:0]  in_block_height,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_placed,
  output      logic [grsp_pkg::POS_W-1:0]  out_pos_u,
  output      logic [grsp_pkg::POS_W-1:0]  out_pos_v,
  output      logic                        out_page_full,
  output      logic                        out_overflow
);
  import grsp_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int SW    = 4 * CB;
  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int XW    = (CB > BLK_W) ? CB : BLK_W;  // compare width

  localparam logic [CNT_W:0]   MAX_WIDE = (CNT_W + 1)'(MAX_SLOTS);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SLOTS);

  // logical list position -> RAM entry; off <= MAX_SLOTS, so one wrap at most
  function automatic logic [AW-1:0] phys(input logic [AW-1:0]    hd,
                                         input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - AW){1'b0}}, hd} + {1'b0, off};
    if (sum >= MAX_WIDE) begin
      sum = sum - MAX_WIDE;
    end
    return sum[AW-1:0];
  endfunction

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  grsp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Registers
  logic [CFG_W-1:0] page_w_r, page_h_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [XW-1:0]    bw_r, bw_nxt, bh_r, bh_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt, tag_r, tag_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] sh_idx_r, sh_idx_nxt, wtag_r, wtag_nxt;
  logic             wpend_r, wpend_nxt;
  logic [CB-1:0]    su_r, su_nxt, sv_r, sv_nxt, sw_r, sw_nxt, sh_r, sh_nxt;
  logic             placed_r, placed_nxt, ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             o_placed_r, o_placed_nxt, o_full_r, o_full_nxt;
  logic             o_ovf_r, o_ovf_nxt;
  logic [POS_W-1:0] o_u_r, o_u_nxt, o_v_r, o_v_nxt;

  // Read-data fields {u, v, w, h}
  logic [CB-1:0] rd_u, rd_v, rd_w, rd_h;
  assign rd_u = ram_rdata[4*CB-1:3*CB];
  assign rd_v = ram_rdata[3*CB-1:2*CB];
  assign rd_w = ram_rdata[2*CB-1:CB];
  assign rd_h = ram_rdata[CB-1:0];

  logic fit;
  assign fit = (bw_r <= XW'(rd_w)) && (bh_r <= XW'(rd_h));

  // Split arithmetic on the captured slot
  logic [XW:0]   ru_sum, bv_sum;
  logic [XW-1:0] rw_diff, bh_diff, su_x, sv_x, bh_x, pw_x, ph_x;
  logic          rs_need, bs_need;
  assign ru_sum  = (XW + 1)'(su_r) + (XW + 1)'(bw_r);
  assign bv_sum  = (XW + 1)'(sv_r) + (XW + 1)'(bh_r);
  assign rw_diff = XW'(sw_r) - bw_r;
  assign bh_diff = XW'(sh_r) - bh_r;
  assign rs_need = XW'(sw_r) > bw_r;
  assign bs_need = XW'(sh_r) > bh_r;
  assign su_x    = XW'(su_r);
  assign sv_x    = XW'(sv_r);
  assign bh_x    = bh_r;
  assign pw_x    = XW'(page_w_r);
  assign ph_x    = XW'(page_h_r);

  // Status
  assign sts.in_kind    = in_kind;
  assign sts.in_skip    = (in_block_width == '0) || (in_block_height == '0) ||
                          (count_r == '0);
  assign sts.hit        = pend_r && fit;
  assign sts.miss       = pend_r && !fit && ((tag_r + CNT_W'(1)) == count_r);
  assign sts.shift_done = (sh_idx_r == '0) && !wpend_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_w_r <= PAGE_SIZE_RST;
      page_h_r <= PAGE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PAGE_WIDTH:  page_w_r <= cfg_wdata;
        CFG_PAGE_HEIGHT: page_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    bw_nxt        = bw_r;
    bh_nxt        = bh_r;
    iss_nxt       = iss_r;
    tag_nxt       = tag_r;
    pend_nxt      = pend_r;
    sh_idx_nxt    = sh_idx_r;
    wtag_nxt      = wtag_r;
    wpend_nxt     = wpend_r;
    su_nxt        = su_r;
    sv_nxt        = sv_r;
    sw_nxt        = sw_r;
    sh_nxt        = sh_r;
    placed_nxt    = placed_r;
    ovf_nxt       = ovf_r;
    o_placed_nxt  = o_placed_r;
    o_u_nxt       = o_u_r;
    o_v_nxt       = o_v_r;
    o_full_nxt    = o_full_r;
    o_ovf_nxt     = o_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = '0;
    ram_raddr     = phys(head_r, iss_r);

    if (cmd.load_item) begin
      bw_nxt     = XW'(in_block_width);
      bh_nxt     = XW'(in_block_height);
      iss_nxt    = '0;
      pend_nxt   = 1'b0;
      wpend_nxt  = 1'b0;
      placed_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end

    if (cmd.new_page) begin
      ram_we    = 1'b1;
      ram_waddr = head_r;
      ram_wdata = {{(2 * CB){1'b0}}, pw_x[CB-1:0], ph_x[CB-1:0]};
      count_nxt = CNT_W'(1);
    end

    // first-fit scan: read issued one cycle, compared the next
    if (cmd.scan_step) begin
      if (iss_r < count_r) begin
        pend_nxt = 1'b1;
        tag_nxt  = iss_r;
        iss_nxt  = iss_r + CNT_W'(1);
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && fit) begin
        su_nxt     = rd_u;
        sv_nxt     = rd_v;
        sw_nxt     = rd_w;
        sh_nxt     = rd_h;
        placed_nxt = 1'b1;
        sh_idx_nxt = tag_r;
        wpend_nxt  = 1'b0;
      end
    end

    // move list positions 0..j-1 up by one, back to front from j downward
    if (cmd.shift_step) begin
      ram_raddr = phys(head_r, (sh_idx_r == '0) ? '0 : sh_idx_r - CNT_W'(1));
      if (sh_idx_r != '0) begin
        wpend_nxt  = 1'b1;
        wtag_nxt   = sh_idx_r;
        sh_idx_nxt = sh_idx_r - CNT_W'(1);
      end else begin
        wpend_nxt = 1'b0;
      end
      if (wpend_r) begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, wtag_r);
        ram_wdata = ram_rdata;
      end
    end

    // front entry is free now: right split fills it, else the list shrinks
    if (cmd.right_split) begin
      if (rs_need) begin
        ram_we    = 1'b1;
        ram_waddr = head_r;
        ram_wdata = {ru_sum[CB-1:0], sv_r, rw_diff[CB-1:0], bh_x[CB-1:0]};
      end else begin
        head_nxt  = phys(head_r, CNT_W'(1));
        count_nxt = count_r - CNT_W'(1);
      end
    end

    if (cmd.bottom_split && bs_need) begin
      if (count_r < MAX_CNT) begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, count_r);
        ram_wdata = {su_r, bv_sum[CB-1:0], sw_r, bh_diff[CB-1:0]};
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
      o_placed_nxt  = placed_r;
      o_u_nxt       = placed_r ? su_x[POS_W-1:0] : '0;
      o_v_nxt       = placed_r ? sv_x[POS_W-1:0] : '0;
      o_full_nxt    = (count_r == '0);
      o_ovf_nxt     = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bw_r       <= bw_nxt;
    bh_r       <= bh_nxt;
    iss_r      <= iss_nxt;
    tag_r      <= tag_nxt;
    sh_idx_r   <= sh_idx_nxt;
    wtag_r     <= wtag_nxt;
    su_r       <= su_nxt;
    sv_r       <= sv_nxt;
    sw_r       <= sw_nxt;
    sh_r       <= sh_nxt;
    placed_r   <= placed_nxt;
    ovf_r      <= ovf_nxt;
    o_placed_r <= o_placed_nxt;
    o_u_r      <= o_u_nxt;
    o_v_r      <= o_v_nxt;
    o_full_r   <= o_full_nxt;
    o_ovf_r    <= o_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_placed    = o_placed_r;
  assign out_pos_u     = o_u_r;
  assign out_pos_v     = o_v_r;
  assign out_page_full = o_full_r;
  assign out_overflow  = o_ovf_r;

endmodule
`default_nettype wire

// ===== sv/grsp_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grsp_chk: port-level checks of the slot packer
// Bound to the top level; watches only its channel ports.
// ----------------------------------------------------------------------------
module grsp_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_placed,
  input wire logic [grsp_pkg::POS_W-1:0] out_pos_u,
  input wire logic [grsp_pkg::POS_W-1:0] out_pos_v,
  input wire logic                       out_page_full,
  input wire logic                       out_overflow
);

  // one item in flight: the beat just taken blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_unplaced_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_placed |-> (out_pos_u == '0) && (out_pos_v == '0))
    else $error("unplaced block with nonzero position");

  // a dropped split only happens on a placement that left the store full
  a_ovf_placed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_placed && !out_page_full)
    else $error("overflow without a placement into a full store");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_placed) &&
      $stable(out_pos_u) && $stable(out_pos_v) && $stable(out_page_full) &&
      $stable(out_overflow))
    else $error("result beat changed while stalled");

endmodule

bind guillotine_rect_slot_packer_core grsp_chk u_grsp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_placed    (out_chan.placed),
  .out_pos_u     (out_chan.pos_u),
  .out_pos_v     (out_chan.pos_v),
  .out_page_full (out_chan.page_full),
  .out_overflow  (out_chan.overflow)
);
`default_nettype wire
